>>> hw/rtl/fte_pkg.sv
// Shared types, constants and match helpers for the fact table rule engine.
// No dependencies.
package fte_pkg;

	localparam int FACT_DEPTH = 256;
	localparam int RULE_DEPTH = 16;
	localparam int ARG_WIDTH  = 16;
	localparam int PRED_WIDTH = 10;
	localparam int FACT_AW    = $clog2(FACT_DEPTH);
	localparam int RULE_AW    = $clog2(RULE_DEPTH);
	localparam int CNT_W      = FACT_AW + 1;
	localparam int RCNT_W     = RULE_AW + 1;
	localparam int ATOM_W     = PRED_WIDTH + 3 * ARG_WIDTH;
	localparam int RULE_W     = 2 * ATOM_W;

	localparam logic [PRED_WIDTH-1:0] PRED_FORBID = PRED_WIDTH'(999);
	localparam logic [PRED_WIDTH-1:0] PRED_PERMIT = PRED_WIDTH'(998);

	localparam logic [2:0] KIND_ADD   = 3'd0;
	localparam logic [2:0] KIND_QUERY = 3'd1;
	localparam logic [2:0] KIND_APPLY = 3'd2;
	localparam logic [2:0] KIND_CHECK = 3'd3;
	localparam logic [2:0] KIND_STORE = 3'd4;
	localparam logic [2:0] KIND_RUN   = 3'd5;

	localparam logic REG_RULE_COUNT = 1'b0;

	typedef struct packed {
		logic [2:0]                  kind;
		logic [PRED_WIDTH-1:0]       pred;
		logic signed [ARG_WIDTH-1:0] arg_first;
		logic signed [ARG_WIDTH-1:0] arg_second;
		logic signed [ARG_WIDTH-1:0] arg_third;
		logic [PRED_WIDTH-1:0]       hd_pred;
		logic signed [ARG_WIDTH-1:0] head_first;
		logic signed [ARG_WIDTH-1:0] head_second;
		logic signed [ARG_WIDTH-1:0] head_third;
		logic [RULE_AW-1:0]          rule_slot;
	} req_t;

	typedef struct packed {
		logic             found;
		logic             fired;
		logic             permitted;
		logic             full_res;
		logic [8:0]       pass_count;
		logic [CNT_W-1:0] fact_total;
	} res_t;

	typedef struct packed {
		logic [PRED_WIDTH-1:0]       pred;
		logic signed [ARG_WIDTH-1:0] a0;
		logic signed [ARG_WIDTH-1:0] a1;
		logic signed [ARG_WIDTH-1:0] a2;
	} atom_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic append_req;
		logic store_rule;
		logic ld_chk;
		logic chk_permit;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic rd_inner;
		logic cap_cand;
		logic use_cand;
		logic append_cand;
		logic set_found;
		logic set_perm;
		logic r_clr;
		logic r_inc;
		logic pass_inc;
		logic chg_clr;
		logic chg_set;
		logic ld_rule;
		logic res_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] kind;
		logic       i_end;
		logic       j_end;
		logic       match;
		logic       n_zero;
		logic       r_last;
		logic       pass_over;
		logic       rfired;
		logic       changed;
		logic       out_free;
	} sts_t;

	// negative probe argument is a wildcard
	function automatic logic fact_match(atom_t f, atom_t p);
		logic m;
		m = (f.pred == p.pred);
		if (!p.a0[ARG_WIDTH-1] && f.a0 != p.a0) m = 1'b0;
		if (!p.a1[ARG_WIDTH-1] && f.a1 != p.a1) m = 1'b0;
		if (!p.a2[ARG_WIDTH-1] && f.a2 != p.a2) m = 1'b0;
		return m;
	endfunction

	// head argument: literal, or copy of an argument of the matched fact
	function automatic logic signed [ARG_WIDTH-1:0] head_sel(
		logic signed [ARG_WIDTH-1:0] h, atom_t f);
		logic signed [ARG_WIDTH-1:0] v;
		if (!h[ARG_WIDTH-1]) v = h;
		else if (h == -ARG_WIDTH'(1)) v = f.a0;
		else if (h == -ARG_WIDTH'(2)) v = f.a1;
		else v = f.a2;
		return v;
	endfunction

endpackage

>>> hw/rtl/fact_table_rule_engine_unit.sv
// Top level of the fact table rule engine: controller plus datapath.
// Depends on fte_pkg, fte_ctrl, fte_dp (and fte_ram through fte_dp).
//
// One request at a time; each gives one result, held in an output register
// so the next request is taken while a result waits. Cost is set by the
// single read port of the fact memory: each fact visited is read, then
// compared. A query scans the table; a permit check scans it for a forbid
// fact and, if none is found, for a permit fact; an apply rule scans it
// and, for every body match, searches the table for a duplicate of the
// derived head; a run loads each rule from the rule store and applies it,
// over all passes. A run stops when a pass fires nothing, or after
// FACT_DEPTH+1 passes. Facts appended during a scan are scanned too.
// A full table drops appends and flags full_res. rule_count is the only
// register, at address 0 of the APB-style port.
module fact_table_rule_engine_unit import fte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	fte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fte_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);
endmodule

>>> hw/rtl/fte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/fte_ctrl.sv
// Sequencer for the rule engine: dispatches requests and steps the scans.
// Depends on fte_pkg.
module fte_ctrl import fte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_QRD, ST_QCMP, ST_ORD, ST_OCMP,
		ST_IRD, ST_ICMP, ST_AEND, ST_RLD, ST_RLAT, ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ph_q, ph_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ph_d    = ph_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.kind)
					KIND_ADD: begin
						cmd.append_req = 1'b1;
						state_d        = ST_DONE;
					end
					KIND_QUERY: begin
						cmd.i_clr = 1'b1;
						state_d   = ST_QRD;
					end
					KIND_APPLY: begin
						cmd.i_clr = 1'b1;
						state_d   = ST_ORD;
					end
					KIND_CHECK: begin
						cmd.ld_chk = 1'b1;
						cmd.i_clr  = 1'b1;
						ph_d       = 1'b0;
						state_d    = ST_QRD;
					end
					KIND_STORE: begin
						cmd.store_rule = 1'b1;
						state_d        = ST_DONE;
					end
					KIND_RUN: begin
						if (sts.n_zero) state_d = ST_DONE;
						else begin
							cmd.r_clr   = 1'b1;
							cmd.chg_clr = 1'b1;
							state_d     = ST_RLD;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_QRD: begin
				if (sts.i_end) begin
					if (sts.kind == KIND_CHECK && !ph_q) begin
						// no forbid fact: look for a permit fact
						cmd.ld_chk     = 1'b1;
						cmd.chk_permit = 1'b1;
						cmd.i_clr      = 1'b1;
						ph_d           = 1'b1;
					end else state_d = ST_DONE;
				end else state_d = ST_QCMP;
			end
			ST_QCMP: begin
				if (sts.match) begin
					if (sts.kind == KIND_QUERY) cmd.set_found = 1'b1;
					else if (ph_q) cmd.set_perm = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = ST_QRD;
				end
			end
			ST_ORD: begin
				state_d = sts.i_end ? ST_AEND : ST_OCMP;
			end
			ST_OCMP: begin
				if (sts.match) begin
					cmd.cap_cand = 1'b1;
					cmd.j_clr    = 1'b1;
					state_d      = ST_IRD;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = ST_ORD;
				end
			end
			ST_IRD: begin
				cmd.rd_inner = 1'b1;
				if (sts.j_end) begin
					cmd.append_cand = 1'b1;
					cmd.i_inc       = 1'b1;
					state_d         = ST_ORD;
				end else state_d = ST_ICMP;
			end
			ST_ICMP: begin
				cmd.use_cand = 1'b1;
				if (sts.match) begin
					cmd.i_inc = 1'b1;
					state_d   = ST_ORD;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = ST_IRD;
				end
			end
			ST_AEND: begin
				if (sts.kind != KIND_RUN) state_d = ST_DONE;
				else if (!sts.r_last) begin
					cmd.chg_set = sts.rfired;
					cmd.r_inc   = 1'b1;
					state_d     = ST_RLD;
				end else begin
					cmd.pass_inc = 1'b1;
					if ((sts.changed || sts.rfired) && !sts.pass_over) begin
						cmd.r_clr   = 1'b1;
						cmd.chg_clr = 1'b1;
						state_d     = ST_RLD;
					end else state_d = ST_DONE;
				end
			end
			ST_RLD:  state_d = ST_RLAT;
			ST_RLAT: begin
				cmd.ld_rule = 1'b1;
				cmd.i_clr   = 1'b1;
				state_d     = ST_ORD;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end
endmodule

>>> hw/rtl/fte_dp.sv
// Datapath: fact and rule memories, scan counters, matcher, result register
// and configuration register. Depends on fte_pkg and fte_ram.
module fte_dp import fte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  req_t        req,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res
);
	req_t  req_q;
	atom_t body_q, head_q, cand_q, fact_rd, probe, req_body, req_head;
	logic [CNT_W-1:0]   count_q, i_q, j_q;
	logic [RULE_AW-1:0] r_q;
	logic [8:0]         pass_q;
	logic [4:0]         rule_count_q;
	logic [RCNT_W-1:0]  n_rules;
	logic found_q, perm_q, full_q, rfired_q, changed_q, res_valid_q;
	logic [ATOM_W-1:0] fact_rdata, fact_wdata;
	logic [RULE_W-1:0] rule_rdata;
	logic fact_we, tbl_full, do_append;
	res_t res_q;

	assign req_body = '{pred: req_q.pred, a0: req_q.arg_first,
		a1: req_q.arg_second, a2: req_q.arg_third};
	assign req_head = '{pred: req_q.hd_pred, a0: req_q.head_first,
		a1: req_q.head_second, a2: req_q.head_third};

	assign tbl_full   = (count_q >= CNT_W'(FACT_DEPTH));
	assign do_append  = cmd.append_req | cmd.append_cand;
	assign fact_we    = do_append & ~tbl_full;
	assign fact_wdata = cmd.append_req ? req_body : cand_q;

	fte_ram #(.WIDTH(ATOM_W), .DEPTH(FACT_DEPTH)) u_fact_ram (
		.clk   (clk),
		.we    (fact_we),
		.waddr (count_q[FACT_AW-1:0]),
		.wdata (fact_wdata),
		.raddr (cmd.rd_inner ? j_q[FACT_AW-1:0] : i_q[FACT_AW-1:0]),
		.rdata (fact_rdata)
	);

	fte_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rule_ram (
		.clk   (clk),
		.we    (cmd.store_rule),
		.waddr (req_q.rule_slot),
		.wdata ({req_body, req_head}),
		.raddr (r_q),
		.rdata (rule_rdata)
	);

	assign fact_rd = fact_rdata;
	assign probe   = cmd.use_cand ? cand_q : body_q;

	// rule_count above the store depth uses the whole store
	assign n_rules = (rule_count_q > 5'(RULE_DEPTH)) ? RCNT_W'(RULE_DEPTH)
		: RCNT_W'(rule_count_q);

	assign sts.kind      = req_q.kind;
	assign sts.i_end     = (i_q >= count_q);
	assign sts.j_end     = (j_q >= count_q);
	assign sts.match     = fact_match(fact_rd, probe);
	assign sts.n_zero    = (n_rules == '0);
	assign sts.r_last    = ({1'b0, r_q} + RCNT_W'(1)) >= n_rules;
	assign sts.pass_over = (pass_q >= 9'(FACT_DEPTH));
	assign sts.rfired    = rfired_q;
	assign sts.changed   = changed_q;
	assign sts.out_free  = ~res_valid_q | ~res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign prdata    = (paddr[2] == REG_RULE_COUNT) ? {27'd0, rule_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			r_q          <= '0;
			pass_q       <= '0;
			rule_count_q <= '0;
			found_q      <= 1'b0;
			perm_q       <= 1'b0;
			full_q       <= 1'b0;
			rfired_q     <= 1'b0;
			changed_q    <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == REG_RULE_COUNT)
				rule_count_q <= pwdata[4:0];
			if (cmd.accept) begin
				found_q  <= 1'b0;
				perm_q   <= 1'b0;
				full_q   <= 1'b0;
				rfired_q <= 1'b0;
				pass_q   <= '0;
			end
			if (do_append) begin
				if (tbl_full) full_q <= 1'b1;
				else count_q <= count_q + CNT_W'(1);
			end
			if (cmd.append_cand) rfired_q <= 1'b1;
			if (cmd.ld_rule) rfired_q <= 1'b0;
			if (cmd.set_found) found_q <= 1'b1;
			if (cmd.set_perm) perm_q <= 1'b1;
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + CNT_W'(1);
			if (cmd.j_clr) j_q <= '0;
			else if (cmd.j_inc) j_q <= j_q + CNT_W'(1);
			if (cmd.r_clr) r_q <= '0;
			else if (cmd.r_inc) r_q <= r_q + RULE_AW'(1);
			if (cmd.pass_inc) pass_q <= pass_q + 9'd1;
			if (cmd.chg_clr) changed_q <= 1'b0;
			else if (cmd.chg_set) changed_q <= 1'b1;
			if (cmd.res_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req;
			body_q <= '{pred: req.pred, a0: req.arg_first,
				a1: req.arg_second, a2: req.arg_third};
			head_q <= '{pred: req.hd_pred, a0: req.head_first,
				a1: req.head_second, a2: req.head_third};
		end
		if (cmd.ld_chk) begin
			body_q.pred <= cmd.chk_permit ? PRED_PERMIT : PRED_FORBID;
			body_q.a0   <= {{(ARG_WIDTH-PRED_WIDTH){1'b0}}, req_q.pred};
			body_q.a1   <= req_q.arg_first;
			body_q.a2   <= req_q.arg_second;
		end
		if (cmd.ld_rule) begin
			body_q <= rule_rdata[RULE_W-1:ATOM_W];
			head_q <= rule_rdata[ATOM_W-1:0];
		end
		if (cmd.cap_cand) begin
			cand_q.pred <= head_q.pred;
			cand_q.a0   <= head_sel(head_q.a0, fact_rd);
			cand_q.a1   <= head_sel(head_q.a1, fact_rd);
			cand_q.a2   <= head_sel(head_q.a2, fact_rd);
		end
		if (cmd.res_load) begin
			res_q.found      <= found_q;
			res_q.fired      <= (req_q.kind == KIND_APPLY) & rfired_q;
			res_q.permitted  <= perm_q;
			res_q.full_res   <= full_q;
			res_q.pass_count <= pass_q;
			res_q.fact_total <= count_q;
		end
	end
endmodule

>>> hw/rtl/fte_checker.sv
// Port-level checks for the rule engine, bound to the top level.
// Depends on fte_pkg and fact_table_rule_engine_unit.
module fte_checker import fte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in progress");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	a_pass_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.pass_count <= 9'(FACT_DEPTH + 1))
		else $error("pass count beyond limit");

	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.fact_total <= CNT_W'(FACT_DEPTH))
		else $error("fact total beyond depth");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.found || res.fired || res.permitted) |->
		res.pass_count == '0)
		else $error("run result mixed with other flags");
endmodule

bind fact_table_rule_engine_unit fte_checker u_fte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

>>> tb/fte_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the fact table rule engine: predicts each result from the
// requests and config writes it sees, then compares. Depends on fte_pkg.
module fte_result_checker import fte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	localparam logic [2:0] ADDR_RULE_COUNT = {REG_RULE_COUNT, 2'b00};

	atom_t      facts [FACT_DEPTH];
	atom_t      bodies[RULE_DEPTH];
	atom_t      heads [RULE_DEPTH];
	int         n_facts  = 0;
	logic [4:0] rule_cnt = '0;
	bit         full_hit;
	res_t       expected_results[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic bit fact_fits(atom_t f, atom_t p);
		if (f.pred != p.pred) return 0;
		if (p.a0 >= 0 && f.a0 != p.a0) return 0;
		if (p.a1 >= 0 && f.a1 != p.a1) return 0;
		if (p.a2 >= 0 && f.a2 != p.a2) return 0;
		return 1;
	endfunction

	function automatic bit table_has(atom_t p);
		for (int i = 0; i < n_facts; i++)
			if (fact_fits(facts[i], p)) return 1;
		return 0;
	endfunction

	function automatic bit table_append(atom_t a);
		if (n_facts >= FACT_DEPTH) return 0;
		facts[n_facts] = a;
		n_facts++;
		return 1;
	endfunction

	function automatic logic signed [ARG_WIDTH-1:0] head_value(
		logic signed [ARG_WIDTH-1:0] h, atom_t f);
		if (h >= 0) return h;
		if (h == -1) return f.a0;
		if (h == -2) return f.a1;
		return f.a2;
	endfunction

	// scan grows with n_facts, so heads appended here get scanned too
	function automatic bit derive_heads(atom_t body, atom_t head);
		bit    fired;
		atom_t h;
		fired = 0;
		for (int i = 0; i < n_facts; i++) begin
			if (!fact_fits(facts[i], body)) continue;
			h.pred = head.pred;
			h.a0 = head_value(head.a0, facts[i]);
			h.a1 = head_value(head.a1, facts[i]);
			h.a2 = head_value(head.a2, facts[i]);
			if (table_has(h)) continue;
			if (!table_append(h)) full_hit = 1;
			fired = 1;
		end
		return fired;
	endfunction

	function automatic res_t evaluate_request(req_t r);
		res_t  o;
		atom_t body, head, probe;
		int    n, passes;
		bit    changed;
		o = '0;
		body = '{r.pred, r.arg_first, r.arg_second, r.arg_third};
		head = '{r.hd_pred, r.head_first, r.head_second, r.head_third};
		full_hit = 0;
		case (r.kind)
			KIND_ADD: o.full_res = !table_append(body);
			KIND_QUERY: o.found = table_has(body);
			KIND_APPLY: begin
				o.fired = derive_heads(body, head);
				o.full_res = full_hit;
			end
			KIND_CHECK: begin
				probe = '{PRED_FORBID, ARG_WIDTH'(r.pred), r.arg_first, r.arg_second};
				if (!table_has(probe)) begin
					probe.pred = PRED_PERMIT;
					o.permitted = table_has(probe);
				end
			end
			KIND_STORE: begin
				bodies[r.rule_slot] = body;
				heads[r.rule_slot] = head;
			end
			KIND_RUN: begin
				n = (rule_cnt > RULE_DEPTH) ? RULE_DEPTH : rule_cnt;
				passes = 0;
				if (n != 0) begin
					changed = 1;
					while (changed) begin
						changed = 0;
						for (int k = 0; k < n; k++)
							if (derive_heads(bodies[k], heads[k])) changed = 1;
						passes++;
						if (passes > FACT_DEPTH) break;
					end
				end
				o.pass_count = 9'(passes);
				o.full_res = full_hit;
			end
			default: ;
		endcase
		o.fact_total = CNT_W'(n_facts);
		return o;
	endfunction

	task automatic report(string field, int got, int exp);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, exp);
		errors++;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			// pop before push: a result never belongs to a same-edge request
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected result, fact_total", res.fact_total, -1);
				end else begin
					e = expected_results.pop_front();
					if (res.found != e.found) report("found", res.found, e.found);
					if (res.fired != e.fired) report("fired", res.fired, e.fired);
					if (res.permitted != e.permitted)
						report("permitted", res.permitted, e.permitted);
					if (res.full_res != e.full_res)
						report("full_res", res.full_res, e.full_res);
					if (res.pass_count != e.pass_count)
						report("pass_count", res.pass_count, e.pass_count);
					if (res.fact_total != e.fact_total)
						report("fact_total", res.fact_total, e.fact_total);
				end
			end
			if (req_valid && !req_stall)
				expected_results.push_back(evaluate_request(req));
			if (psel && penable && pwrite && pready && paddr == ADDR_RULE_COUNT)
				rule_cnt = pwdata[4:0];
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/fact_table_rule_engine_unit_tb.sv
`timescale 1ns / 100ps
// Top of the fact table rule engine testbench: clock, reset, request and
// config stimulus, verdict. Depends on fte_pkg, the unit and fte_result_checker.
module fact_table_rule_engine_unit_tb;
	import fte_pkg::*;

	// fact count from which random traffic stops growing the table
	localparam int GROW_CAP = 60;

	logic        clk = 0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;
	int          facts_seen = 0;
	bit          tx_quiet = 0;
	bit          rx_quiet = 0;
	int          rx_hold = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	fact_table_rule_engine_unit i_dut (
		.clk, .arst_n, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	fte_result_checker i_chk (
		.clk, .arst_n, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
	);

	// table size as last reported; paces how much random traffic may grow it
	always @(posedge clk)
		if (res_valid && !res_stall) facts_seen <= res.fact_total;

	// result side stalls: mostly short, a few long, with quiet stretches
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			res_stall <= 1'b1;
		end else if (rx_quiet || r < 70) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= 1'b1;
			rx_hold <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 50);
		end
		if ($urandom_range(0, 299) == 0) rx_quiet <= !rx_quiet;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// hold the request until taken, then maybe drop valid for a gap
	task automatic send(req_t r);
		int gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		gap = gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rule_count(logic [4:0] n);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_RULE_COUNT, 2'b00};
		pwdata <= {27'($urandom), n};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic req_t item(logic [2:0] kind, int pred, int a0, int a1, int a2,
		int hp = 12, int h0 = -1, int h1 = -2, int h2 = -3, int slot = 0);
		req_t r;
		r.kind = kind;
		r.pred = PRED_WIDTH'(pred);
		r.arg_first = ARG_WIDTH'(a0);
		r.arg_second = ARG_WIDTH'(a1);
		r.arg_third = ARG_WIDTH'(a2);
		r.hd_pred = PRED_WIDTH'(hp);
		r.head_first = ARG_WIDTH'(h0);
		r.head_second = ARG_WIDTH'(h1);
		r.head_third = ARG_WIDTH'(h2);
		r.rule_slot = RULE_AW'(slot);
		return r;
	endfunction

	function automatic int fact_arg();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3) : int'($urandom);
	endfunction

	// query and body arguments: small literal, negative wildcard, or anything
	function automatic int probe_arg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom_range(0, 3);
		if (r < 90) return int'({1'b1, 15'($urandom)});
		return int'($urandom);
	endfunction

	// head selectors: mostly copies, some below -3, some literals
	function automatic int head_arg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return -int'($urandom_range(1, 3));
		if (r < 60) return int'({1'b1, 15'($urandom)});
		if (r < 97) return $urandom_range(0, 3);
		return int'($urandom);
	endfunction

	function automatic int pick_pred();
		return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5) : $urandom_range(8, 11);
	endfunction

	function automatic req_t random_item(int rules);
		req_t r;
		int   w, run_w;
		bit   grow_ok;
		grow_ok = facts_seen < GROW_CAP;
		run_w = (rules > 4) ? 2 : 5;
		w = $urandom_range(0, 99);
		if (w < 6) begin
			// noise: every field arbitrary
			r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
			if (!grow_ok && (r.kind == KIND_ADD || r.kind == KIND_APPLY || r.kind == KIND_RUN))
				r.kind = KIND_QUERY;
			if (r.kind == KIND_RUN && rules > 4) r.kind = KIND_CHECK;
			return r;
		end
		w = $urandom_range(0, 99);
		if (!grow_ok && (w < 15 || (w >= 45 && w < 55) || (w >= 85 && w < 85 + run_w)))
			w = 20;
		if (w < 15) begin
			if ($urandom_range(0, 4) == 0)
				return item(KIND_ADD, ($urandom_range(0, 1) != 0) ? PRED_PERMIT : PRED_FORBID,
					$urandom_range(0, 3), fact_arg(), fact_arg(), $urandom, $urandom,
					$urandom, $urandom, $urandom);
			return item(KIND_ADD, $urandom_range(0, 5), fact_arg(), fact_arg(), fact_arg(),
				$urandom, $urandom, $urandom, $urandom, $urandom);
		end
		if (w < 45)
			return item(KIND_QUERY, pick_pred(), probe_arg(), probe_arg(), probe_arg(),
				$urandom, $urandom, $urandom, $urandom, $urandom);
		if (w < 55)
			return item(KIND_APPLY, pick_pred(), probe_arg(), probe_arg(), probe_arg(),
				$urandom_range(8, 11), head_arg(), head_arg(), head_arg(), $urandom);
		if (w < 72)
			return item(KIND_CHECK, $urandom_range(0, 3), fact_arg(), fact_arg(), $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		if (w < 85)
			return item(KIND_STORE, pick_pred(), probe_arg(), probe_arg(), probe_arg(),
				$urandom_range(8, 11), head_arg(), head_arg(), head_arg(),
				$urandom_range(0, 15));
		if (w < 85 + run_w)
			return item(KIND_RUN, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		return item(($urandom_range(0, 1) != 0) ? 3'd6 : 3'd7, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	initial begin
		int rule_settings[8] = '{2, 16, 0, 31, 1, 4, 3, 2};
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, permit and forbid, dedup, odd kinds
		send(item(KIND_QUERY, 0, -1, -1, -1));
		send(item(KIND_ADD, 0, 0, 0, 0));
		send(item(KIND_ADD, 1023, 32767, -32768, -1));
		send(item(KIND_ADD, 5, 1, 2, 3));
		send(item(KIND_QUERY, 0, 0, 0, 0));
		send(item(KIND_QUERY, 5, 1, 2, 4));
		send(item(KIND_QUERY, 1023, -32768, -1, -5));
		send(item(KIND_ADD, PRED_PERMIT, 5, 1, 2));
		send(item(KIND_CHECK, 5, 1, 2, 9));
		send(item(KIND_ADD, PRED_PERMIT, 3, 0, 0));
		send(item(KIND_ADD, PRED_FORBID, 3, 0, 0));
		send(item(KIND_CHECK, 3, 0, 0, 0));
		send(item(KIND_CHECK, 1023, 32767, -32768, 0));
		send(item(KIND_APPLY, 0, -1, -1, -1, 9, -1, -2, -3));
		send(item(KIND_APPLY, 0, -1, -1, -1, 9, -1, -2, -3));
		// selector below -3 copies the third argument; negative copies dedup as wildcards
		send(item(KIND_APPLY, 1023, -1, -1, -1, 1023, -7, 32767, -2));
		send(item(KIND_APPLY, 1023, 32767, -1, -1, 10, -2, -2, -2));
		send(item(3'd6, 1023, -1, -1, -1, 1023, -1, -1, -1, 15));
		send(item(3'd7, 0, 0, 0, 0));
		// every rule slot written before any run can reach it
		for (int s = 0; s < RULE_DEPTH; s++)
			send(item(KIND_STORE, 1000 + s, 0, 0, 0, 12, -1, -2, -3, s));
		send(item(KIND_RUN, 0, 0, 0, 0));

		// random phases, one rule_count setting each
		foreach (rule_settings[p]) begin
			drain();
			write_rule_count(5'(rule_settings[p]));
			repeat (90) send(random_item(rule_settings[p]));
		end

		// full table: a unique body fact, then fill, then apply and run into it
		drain();
		write_rule_count(5'd1);
		send(item(KIND_ADD, 7, 5, 5, 5));
		send(item(KIND_STORE, 7, 5, 5, 5, 13, 5, 5, 5, 0));
		while (facts_seen < FACT_DEPTH) begin
			send(item(KIND_ADD, 6, fact_arg(), fact_arg(), fact_arg()));
			if (pending > 4) drain();
		end
		send(item(KIND_ADD, 6, 1, 1, 1));
		send(item(KIND_APPLY, 7, 5, 5, 5, 13, 5, 5, 5));
		// keeps firing into a full table, so it stops at the pass limit
		send(item(KIND_RUN, 0, 0, 0, 0));
		send(item(KIND_QUERY, 7, -1, -1, -1));
		send(item(KIND_CHECK, 5, 1, 2, 0));
		send(item(3'd6, 0, 0, 0, 0));

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
